// File: hdl/double_ended_queue_assert.svh
// ---------------------------------------------------------------------------
// double_ended_queue assertion macros
// concurrent assertion helpers shared by the deque rtl
// ---------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DEQ_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// next-cycle implication, checked out of reset
`define DEQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`endif

// File: hdl/deq_pkg.sv
// ---------------------------------------------------------------------------
// deq_pkg
// sizes, codes and controller/datapath interface types of the deque
// ---------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 64;
    localparam int PTR_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int SUM_W       = CNT_W + 1;

    // fixed field widths
    localparam int OP_W   = 2;
    localparam int POS_W  = 4;
    localparam int DATA_W = 64;
    localparam int ST_W   = 2;
    localparam int LEN_W  = 5;

    typedef logic [OP_W-1:0] opcode_t;
    typedef logic [ST_W-1:0] status_t;

    localparam opcode_t OP_PUT  = 2'd0;
    localparam opcode_t OP_GET  = 2'd1;
    localparam opcode_t OP_READ = 2'd2;
    localparam opcode_t OP_REM  = 2'd3;

    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_MISS = 2'd1;
    localparam status_t ST_FULL = 2'd2;

    localparam logic END_HEAD = 1'b0;

    // source of the logical read index
    typedef enum logic [1:0] {
        RD_POS,
        RD_SCAN,
        RD_NEXT
    } rd_mode_t;

    // what the result register is loaded with
    typedef enum logic [2:0] {
        RES_OK,
        RES_MISS,
        RES_FULL,
        RES_DATA,
        RES_MATCH
    } res_sel_t;

    typedef struct packed {
        logic     accept;
        logic     rd_en;
        rd_mode_t rd_mode;
        logic     put;
        logic     pop;
        logic     found;
        logic     idx_inc;
        logic     move_wr;
        logic     shrink;
        logic     load_result;
        res_sel_t res_sel;
    } deq_cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    full;
        logic    empty;
        logic    pos_oob;
        logic    match;
        logic    idx_last;
        logic    out_free;
    } deq_stat_t;

    // physical slot of logical element li counted from the head
    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
                                                 input logic [CNT_W-1:0] li);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(li);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return PTR_W'(sum);
    endfunction

endpackage

// File: hdl/deq_datapath.sv
// ---------------------------------------------------------------------------
// deq_datapath
// entry memory, head/count pointers, scan index and result register
// ---------------------------------------------------------------------------
module deq_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  deq_pkg::deq_cmd_t          cmd,
    output deq_pkg::deq_stat_t         stat,
    input  deq_pkg::opcode_t           s_opcode,
    input  logic                       s_end_select,
    input  logic [deq_pkg::DATA_W-1:0] s_item_value,
    input  logic [deq_pkg::POS_W-1:0]  s_position,
    input  logic                       m_ready,
    output logic                       m_valid,
    output logic [deq_pkg::DATA_W-1:0] m_result_value,
    output deq_pkg::status_t           m_status,
    output logic [deq_pkg::LEN_W-1:0]  m_length
);

    // latched request
    deq_pkg::opcode_t                    op_reg;
    logic                                end_reg;
    logic [deq_pkg::VALUE_WIDTH-1:0]     val_reg;
    logic [deq_pkg::POS_W-1:0]           pos_reg;

    // queue state
    logic [deq_pkg::PTR_W-1:0]           head_reg;
    logic [deq_pkg::CNT_W-1:0]           count_reg;
    logic [deq_pkg::CNT_W-1:0]           idx_reg;

    // memory
    logic [deq_pkg::VALUE_WIDTH-1:0]     mem_q [deq_pkg::DEPTH];
    logic [deq_pkg::VALUE_WIDTH-1:0]     rd_data_reg;

    // result register
    logic                                out_valid_reg;
    logic [deq_pkg::DATA_W-1:0]          out_value_reg;
    deq_pkg::status_t                    out_status_reg;
    logic [deq_pkg::LEN_W-1:0]           out_length_reg;

    logic [deq_pkg::CNT_W-1:0]           last_li;
    logic [deq_pkg::CNT_W-1:0]           scan_li;
    logic [deq_pkg::CNT_W-1:0]           pos_li;
    logic [deq_pkg::CNT_W-1:0]           rd_li;
    logic [deq_pkg::PTR_W-1:0]           rd_addr;
    logic [deq_pkg::PTR_W-1:0]           wr_addr;
    logic [deq_pkg::VALUE_WIDTH-1:0]     wr_data;
    logic                                wr_en;
    logic [deq_pkg::PTR_W-1:0]           head_dec;
    logic [deq_pkg::PTR_W-1:0]           head_inc;

    always_comb begin
        last_li = count_reg - deq_pkg::CNT_W'(1);
        scan_li = end_reg ? (last_li - idx_reg) : idx_reg;
        pos_li  = end_reg ? (last_li - deq_pkg::CNT_W'(pos_reg)) : deq_pkg::CNT_W'(pos_reg);
        case (cmd.rd_mode)
            deq_pkg::RD_POS:  rd_li = pos_li;
            deq_pkg::RD_SCAN: rd_li = scan_li;
            deq_pkg::RD_NEXT: rd_li = idx_reg + deq_pkg::CNT_W'(1);
            default:          rd_li = idx_reg;
        endcase
        rd_addr = deq_pkg::slot_of(head_reg, rd_li);

        head_dec = (head_reg == '0) ? deq_pkg::PTR_W'(deq_pkg::DEPTH - 1)
                                    : head_reg - deq_pkg::PTR_W'(1);
        head_inc = (head_reg == deq_pkg::PTR_W'(deq_pkg::DEPTH - 1)) ? '0
                                    : head_reg + deq_pkg::PTR_W'(1);

        wr_en   = cmd.put || cmd.move_wr;
        wr_data = cmd.put ? val_reg : rd_data_reg;
        if (cmd.put) begin
            wr_addr = (end_reg == deq_pkg::END_HEAD) ? head_dec
                                                     : deq_pkg::slot_of(head_reg, count_reg);
        end else begin
            wr_addr = deq_pkg::slot_of(head_reg, idx_reg);
        end
    end

    // single write port, single registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_q[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem_q[rd_addr];
        end
    end

    // request latch, no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg  <= s_opcode;
            end_reg <= s_end_select;
            val_reg <= s_item_value[deq_pkg::VALUE_WIDTH-1:0];
            pos_reg <= s_position;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
        end else begin
            if (cmd.put) begin
                if (end_reg == deq_pkg::END_HEAD) begin
                    head_reg <= head_dec;
                end
                count_reg <= count_reg + deq_pkg::CNT_W'(1);
            end else if (cmd.pop) begin
                if (end_reg == deq_pkg::END_HEAD) begin
                    head_reg <= head_inc;
                end
                count_reg <= count_reg - deq_pkg::CNT_W'(1);
            end else if (cmd.shrink) begin
                count_reg <= count_reg - deq_pkg::CNT_W'(1);
            end

            if (cmd.accept) begin
                idx_reg <= '0;
            end else if (cmd.found) begin
                idx_reg <= scan_li;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + deq_pkg::CNT_W'(1);
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_result) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            out_length_reg <= deq_pkg::LEN_W'(count_reg);
            case (cmd.res_sel)
                deq_pkg::RES_OK: begin
                    out_value_reg  <= '0;
                    out_status_reg <= deq_pkg::ST_OK;
                end
                deq_pkg::RES_FULL: begin
                    out_value_reg  <= '0;
                    out_status_reg <= deq_pkg::ST_FULL;
                end
                deq_pkg::RES_DATA: begin
                    out_value_reg  <= deq_pkg::DATA_W'(rd_data_reg);
                    out_status_reg <= deq_pkg::ST_OK;
                end
                deq_pkg::RES_MATCH: begin
                    out_value_reg  <= deq_pkg::DATA_W'(val_reg);
                    out_status_reg <= deq_pkg::ST_OK;
                end
                default: begin
                    out_value_reg  <= '0;
                    out_status_reg <= deq_pkg::ST_MISS;
                end
            endcase
        end
    end

    always_comb begin
        stat.op       = op_reg;
        stat.full     = (count_reg == deq_pkg::CNT_W'(deq_pkg::DEPTH));
        stat.empty    = (count_reg == '0);
        stat.pos_oob  = (int'(pos_reg) >= int'(count_reg));
        stat.match    = (rd_data_reg == val_reg);
        stat.idx_last = (idx_reg == last_li);
        stat.out_free = !out_valid_reg || m_ready;
    end

    assign m_valid        = out_valid_reg;
    assign m_result_value = out_value_reg;
    assign m_status       = out_status_reg;
    assign m_length       = out_length_reg;

endmodule

// File: hdl/deq_controller.sv
// ---------------------------------------------------------------------------
// deq_controller
// sequences one request at a time: decode, scan, compaction, result load
// ---------------------------------------------------------------------------
module deq_controller (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  deq_pkg::deq_stat_t  stat,
    output deq_pkg::deq_cmd_t   cmd
);

    typedef enum logic [2:0] {
        IDLE,
        EXEC,
        SCAN_RD,
        SCAN_CMP,
        MOVE_CHK,
        MOVE_WR,
        DONE
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    deq_pkg::res_sel_t res_sel_reg;
    deq_pkg::res_sel_t res_sel_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            res_sel_reg <= deq_pkg::RES_OK;
        end else begin
            state_reg   <= state_next;
            res_sel_reg <= res_sel_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        res_sel_next = res_sel_reg;
        cmd          = '0;
        cmd.rd_mode  = deq_pkg::RD_SCAN;
        cmd.res_sel  = res_sel_reg;
        case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = EXEC;
                end
            end
            EXEC: begin
                state_next = DONE;
                case (stat.op)
                    deq_pkg::OP_PUT: begin
                        if (stat.full) begin
                            res_sel_next = deq_pkg::RES_FULL;
                        end else begin
                            cmd.put      = 1'b1;
                            res_sel_next = deq_pkg::RES_OK;
                        end
                    end
                    deq_pkg::OP_GET: begin
                        if (stat.empty) begin
                            res_sel_next = deq_pkg::RES_MISS;
                        end else begin
                            // scan index is zero here: first element from chosen end
                            cmd.rd_en    = 1'b1;
                            cmd.pop      = 1'b1;
                            res_sel_next = deq_pkg::RES_DATA;
                        end
                    end
                    deq_pkg::OP_READ: begin
                        if (stat.pos_oob) begin
                            res_sel_next = deq_pkg::RES_MISS;
                        end else begin
                            cmd.rd_en    = 1'b1;
                            cmd.rd_mode  = deq_pkg::RD_POS;
                            res_sel_next = deq_pkg::RES_DATA;
                        end
                    end
                    default: begin
                        if (stat.empty) begin
                            res_sel_next = deq_pkg::RES_MISS;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            state_next = SCAN_CMP;
                        end
                    end
                endcase
            end
            SCAN_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = SCAN_CMP;
            end
            SCAN_CMP: begin
                if (stat.match) begin
                    cmd.found    = 1'b1;
                    res_sel_next = deq_pkg::RES_MATCH;
                    state_next   = MOVE_CHK;
                end else if (stat.idx_last) begin
                    res_sel_next = deq_pkg::RES_MISS;
                    state_next   = DONE;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = SCAN_RD;
                end
            end
            MOVE_CHK: begin
                if (stat.idx_last) begin
                    cmd.shrink = 1'b1;
                    state_next = DONE;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_mode = deq_pkg::RD_NEXT;
                    state_next  = MOVE_WR;
                end
            end
            MOVE_WR: begin
                cmd.move_wr = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = MOVE_CHK;
            end
            DONE: begin
                if (stat.out_free) begin
                    cmd.load_result = 1'b1;
                    state_next      = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == IDLE);

endmodule

// File: hdl/double_ended_queue.sv
// ---------------------------------------------------------------------------
// double_ended_queue
// fixed-depth deque of values with head/tail put, get, read and remove
// ---------------------------------------------------------------------------
// One request is worked at a time and each gives exactly one result, which
// carries the queue length after the request. Put, get and read go through
// the steps accept, execute and load, and the next request is taken in the
// cycle after the load. Remove walks the entries one at a time through the
// single read port of the entry memory: a read and a compare step per entry
// compared, then a read and a write step per entry shifted to close the gap
// toward the head. The result sits in an output register; when it is not yet
// taken the next request still gets accepted and worked, and only its result
// load waits. Entries never written are never read. Put on a full queue
// returns status full; get, read or remove that finds nothing returns value
// zero with status not-found, and leaves the queue unchanged.
// ---------------------------------------------------------------------------
`include "double_ended_queue_assert.svh"

module double_ended_queue (
    input  logic                       aclk,
    input  logic                       aresetn,
    // request channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  deq_pkg::opcode_t           s_opcode,
    input  logic                       s_end_select,
    input  logic [deq_pkg::DATA_W-1:0] s_item_value,
    input  logic [deq_pkg::POS_W-1:0]  s_position,
    // result channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [deq_pkg::DATA_W-1:0] m_result_value,
    output deq_pkg::status_t           m_status,
    output logic [deq_pkg::LEN_W-1:0]  m_length
);

    // command and status between sequencer and datapath
    deq_pkg::deq_cmd_t  cmd;
    deq_pkg::deq_stat_t stat;

    // sequencer: decodes the request and steps scan and compaction
    deq_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath: entry memory, pointers and the result register
    deq_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_opcode       (s_opcode),
        .s_end_select   (s_end_select),
        .s_item_value   (s_item_value),
        .s_position     (s_position),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_result_value (m_result_value),
        .m_status       (m_status),
        .m_length       (m_length)
    );

    // a full status only when the queue actually holds DEPTH entries
    `DEQ_ASSERT_NOW(a_full_len, aclk, aresetn, m_valid && (m_status == deq_pkg::ST_FULL), m_length == deq_pkg::LEN_W'(deq_pkg::DEPTH))

    // a miss never carries a value
    `DEQ_ASSERT_NOW(a_miss_zero, aclk, aresetn, m_valid && (m_status == deq_pkg::ST_MISS), m_result_value == '0)

    // length never goes past the depth
    `DEQ_ASSERT_NOW(a_len_bound, aclk, aresetn, m_valid, m_length <= deq_pkg::LEN_W'(deq_pkg::DEPTH))

    // one request at a time: after acceptance the request side closes
    `DEQ_ASSERT_NEXT(a_one_req, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule
